FILE: hw/rtl/csistrip_pkg.sv
// Shared types and byte constants for the CSI escape stripper.
package csistrip_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] EscByte   = 8'h1B;
  localparam logic [7:0] LBracket  = 8'h5B;
  localparam logic [7:0] CrByte    = 8'h0D;
  localparam logic [7:0] ParamLo   = 8'h30;
  localparam logic [7:0] ParamHi   = 8'h3F;
  localparam logic [7:0] InterLo   = 8'h20;
  localparam logic [7:0] InterHi   = 8'h2F;
  localparam logic [7:0] FinalLo   = 8'h40;
  localparam logic [7:0] FinalHi   = 8'h7E;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2,
    MODE_INTER = 2'd3
  } mode_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } beat_t;

  // Up to two result beats produced by one input beat.
  typedef struct packed {
    beat_t      res0;
    beat_t      res1;
    logic [1:0] cnt;
  } push_t;

endpackage

FILE: hw/rtl/csistrip_parse.sv
// Combinational parser: next mode and the result beats of one input byte.
module csistrip_parse
  import csistrip_pkg::*;
(
  input  mode_t      mode,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output mode_t      mode_nxt,
  output push_t      push
);

  logic  is_esc;
  logic  text_emit;
  logic  text_to_esc;
  logic  in_param;
  logic  in_inter;
  logic  in_final;
  mode_t mode_raw;

  assign is_esc      = (data_byte == EscByte);
  // Plain text: ESC is held unless the string ends, CR is dropped.
  assign text_emit   = is_esc ? last_byte : (data_byte != CrByte);
  assign text_to_esc = is_esc && !last_byte;
  assign in_param    = (data_byte inside {[ParamLo:ParamHi]});
  assign in_inter    = (data_byte inside {[InterLo:InterHi]});
  assign in_final    = (data_byte inside {[FinalLo:FinalHi]});

  // Next mode.
  always_comb begin
    mode_raw = MODE_TEXT;
    case (mode)
      MODE_ESC: begin
        if (data_byte == LBracket) begin
          mode_raw = MODE_PARAM;
        end else if (text_to_esc) begin
          mode_raw = MODE_ESC;
        end
      end
      MODE_PARAM, MODE_INTER: begin
        if (mode == MODE_PARAM && in_param) begin
          mode_raw = MODE_PARAM;
        end else if (in_inter) begin
          mode_raw = MODE_INTER;
        end else if (in_final) begin
          mode_raw = MODE_TEXT;
        end else if (text_to_esc) begin
          mode_raw = MODE_ESC;
        end
      end
      default: begin
        if (text_to_esc) begin
          mode_raw = MODE_ESC;
        end
      end
    endcase
    mode_nxt = last_byte ? MODE_TEXT : mode_raw;
  end

  // Result beats.
  always_comb begin
    push = '0;
    case (mode)
      MODE_ESC: begin
        if (data_byte != LBracket) begin
          push.res0 = '{data: EscByte, valid: 1'b1, last: 1'b0};
          push.res1 = '{data: data_byte, valid: 1'b1, last: 1'b0};
          push.cnt  = text_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_PARAM, MODE_INTER: begin
        if (!((mode == MODE_PARAM && in_param) || in_inter || in_final)) begin
          push.res0 = '{data: data_byte, valid: 1'b1, last: 1'b0};
          push.cnt  = text_emit ? 2'd1 : 2'd0;
        end
      end
      default: begin
        push.res0 = '{data: data_byte, valid: 1'b1, last: 1'b0};
        push.cnt  = text_emit ? 2'd1 : 2'd0;
      end
    endcase

    // Mark the end of the string: tag the final beat or emit an empty marker.
    if (last_byte) begin
      case (push.cnt)
        2'd0: begin
          push.res0 = '{data: 8'h00, valid: 1'b0, last: 1'b1};
          push.cnt  = 2'd1;
        end
        2'd1:    push.res0.last = 1'b1;
        default: push.res1.last = 1'b1;
      endcase
    end
  end

endmodule

FILE: hw/rtl/csistrip_fifo.sv
// Result queue that takes up to two beats per cycle and gives one.
module csistrip_fifo
  import csistrip_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepth
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output beat_t head,
  output logic  head_valid,
  input  logic  pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

  function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  beat_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  wr_ptr_p1;
  logic              do_pop;

  assign wr_ptr_p1  = inc_ptr(wr_ptr_r);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room2      = (count_r <= ROOM_MAX);
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = inc_ptr(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = do_pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/ansi_csi_escape_stripper.sv
// Top level of the ANSI CSI escape stripper: input register, parser, result queue.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------------
//   in_     | in  | in_tvalid / in_tready   | tdata = data_byte, tlast = last_byte
//   out_    | out | out_tvalid / out_tready | tdata = out_byte, tuser = out_valid,
//           |     |                       | tlast = out_last
//
// One input beat per cycle sustained while the output keeps up. A beat is held in
// the input register, is parsed there, and its zero to two results land in the
// queue, whose head drives out_. The input register advances only while the
// queue has room for two beats, so a stalled output backs up into in_tready
// once DEPTH-1 beats are queued.
// Synchronous reset clears the parse mode, the input register valid bit and
// the queue; no clearing pass is needed.
module ansi_csi_escape_stripper
  import csistrip_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepth  // result queue depth, 3 or more
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tlast,    // last_byte

  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // [0] out_valid (0 on an empty end marker)
  output logic       out_tlast    // out_last
);

  // Input register stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Parse state, updated once per consumed beat.
  mode_t      mode_r, mode_nxt, mode_calc;

  push_t      push_calc;
  push_t      push;
  logic       room2;
  logic       s1_fire;
  logic       in_fire;
  beat_t      head;
  logic       head_valid;

  // Consume the registered beat when the queue can absorb two results.
  assign s1_fire   = s1_valid_r && room2;
  // Take a new beat whenever the register is empty or drains this cycle.
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  csistrip_parse u_parse (
    .mode      (mode_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .mode_nxt  (mode_calc),
    .push      (push_calc)
  );

  // Drop the push when the register is not consumed this cycle.
  always_comb begin
    push = push_calc;
    if (!s1_fire) begin
      push.cnt = 2'd0;
    end
    mode_nxt     = s1_fire ? mode_calc : mode_r;
    s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);
  end

  csistrip_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .head       (head),
    .head_valid (head_valid),
    .pop        (out_tready)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = head.data;
  assign out_tuser  = head.valid;
  assign out_tlast  = head.last;

  // Hold the payload unless a new beat is taken.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r     <= MODE_TEXT;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      mode_r     <= mode_nxt;
    end
  end

endmodule

FILE: dv/tb_ansi_csi_escape_stripper.sv
// Testbench for the ANSI CSI escape stripper: random and directed byte strings, scoreboard check.
module tb_ansi_csi_escape_stripper;
  import csistrip_pkg::*;

  // Predicts the cleaned stream from the accepted input beats and checks
  // every output beat against the oldest expected beat.
  class strip_scoreboard;
    mode_t mode;
    beat_t cleaned_q[$];   // expected output beats, oldest first
    beat_t step_out[$];    // beats caused by the current input beat
    int    errors;

    function new();
      mode   = MODE_TEXT;
      errors = 0;
    endfunction

    function void pass_byte(logic [7:0] b);
      beat_t bt;
      bt.data  = b;
      bt.valid = 1'b1;
      bt.last  = 1'b0;
      step_out.push_back(bt);
    endfunction

    // Ordinary text: an ESC starts a pending escape unless it closes the
    // string, a CR is dropped, anything else goes through.
    function void take_text(logic [7:0] b, logic lst);
      if (b == EscByte) begin
        if (lst) pass_byte(b);
        else mode = MODE_ESC;
      end else if (b != CrByte) begin
        pass_byte(b);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic lst);
      mode_t prev;
      beat_t marker;
      prev = mode;
      step_out.delete();
      mode = MODE_TEXT;
      case (prev)
        MODE_ESC: begin
          if (b == LBracket) begin
            mode = MODE_PARAM;
          end else begin
            // not a CSI: release the held ESC, then treat b as text
            pass_byte(EscByte);
            take_text(b, lst);
          end
        end
        MODE_PARAM, MODE_INTER: begin
          if (prev == MODE_PARAM && b >= ParamLo && b <= ParamHi) mode = MODE_PARAM;
          else if (b >= InterLo && b <= InterHi) mode = MODE_INTER;
          else if (b >= FinalLo && b <= FinalHi) mode = MODE_TEXT;
          else take_text(b, lst);  // broken sequence: abandon it
        end
        default: take_text(b, lst);
      endcase
      if (lst) begin
        mode = MODE_TEXT;
        if (step_out.size() == 0) begin
          marker.data  = 8'h00;
          marker.valid = 1'b0;
          marker.last  = 1'b1;
          step_out.push_back(marker);
        end else begin
          step_out[step_out.size()-1].last = 1'b1;
        end
      end
      foreach (step_out[i]) cleaned_q.push_back(step_out[i]);
    endfunction

    function void check_beat(logic [7:0] d, logic v, logic l);
      beat_t exp_beat;
      if (cleaned_q.size() == 0) begin
        $error("unexpected output beat: out_byte=%02h out_valid=%0b out_last=%0b", d, v, l);
        errors++;
        return;
      end
      exp_beat = cleaned_q.pop_front();
      if (d !== exp_beat.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", exp_beat.data, d);
        errors++;
      end
      if (v !== exp_beat.valid) begin
        $error("out_valid mismatch: expected %0b, actual %0b", exp_beat.valid, v);
        errors++;
      end
      if (l !== exp_beat.last) begin
        $error("out_last mismatch: expected %0b, actual %0b", exp_beat.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] data_byte
  logic       in_tlast;    // last_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [7:0] out_byte
  logic       out_tuser;   // [0] out_valid
  logic       out_tlast;   // out_last

  strip_scoreboard sb;

  int  send_idle_pct;   // chance per cycle that the sender holds back
  int  recv_stall_pct;  // chance per cycle that the receiver stalls
  bit  holdoff_go;      // ask the receiver for one long hold-off
  bit  holdoff_done;
  int  bytes_sent;

  ansi_csi_escape_stripper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Safety net: the slowest legal run is far shorter than this.
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: decide tready at every falling edge. Once asked, hold off for
  // a long stretch so the result queue fills and in_tready drops.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_go && !holdoff_done) begin
        out_tready <= 1'b0;
        repeat (60) @(negedge clk);
        holdoff_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted output beat at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  // Offer one beat, starting and ending just after a falling edge. tvalid
  // stays high between back-to-back beats.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  // One random string: mostly well-formed CSI sequences with random
  // parameters, mixed with noise, stray ESC, CR and '[' bytes.
  task automatic send_string();
    logic [7:0] txt[$];
    int         len;
    len = $urandom_range(1, 16);
    while (txt.size() < len) begin
      if ($urandom_range(99) < 40) begin
        txt.push_back(EscByte);
        txt.push_back(LBracket);
        repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(ParamLo, ParamHi)));
        repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(InterLo, InterHi)));
        // usually close with a final byte, sometimes break the sequence
        if ($urandom_range(9) != 0) txt.push_back(8'($urandom_range(FinalLo, FinalHi)));
        else txt.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0:       txt.push_back(EscByte);
          1:       txt.push_back(CrByte);
          2:       txt.push_back(LBracket);
          default: txt.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
  endtask

  // Directed strings, {last_byte, data_byte}.
  logic [8:0] directed [28] = '{
    9'h041, 9'h000, 9'h0FF, 9'h10D,            // text, extremes; CR on last -> empty marker
    9'h01B, 9'h05B, 9'h033, 9'h031, 9'h021, 9'h06D,  // full CSI with intermediate
    9'h01B, 9'h01B, 9'h041,                    // ESC ESC: first released, second pending
    9'h01B, 9'h00D,                            // ESC then CR: ESC out, CR dropped
    9'h01B, 9'h05B, 9'h020, 9'h031,            // parameter after intermediate: broken
    9'h01B, 9'h05B, 9'h07F,                    // DEL inside a sequence: broken
    9'h11B,                                    // ESC on the last byte
    9'h01B, 9'h05B, 9'h17E,                    // sequence closes the string
    9'h01B, 9'h178                             // pending ESC, last byte not '['
  };

  int idle_plan [5] = '{0, 1, 2, 3, 0};

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tlast       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_go     = 1'b0;
    holdoff_done   = 1'b0;
    bytes_sent     = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    // Random phases with different idling; the last one runs flat out and
    // includes the long receiver hold-off.
    foreach (idle_plan[p]) begin
      case (idle_plan[p])
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (p == 4) holdoff_go = 1'b1;
      while (bytes_sent < 28 + 180 * (p + 1)) send_string();
    end

    in_tvalid      <= 1'b0;
    recv_stall_pct = 0;
    while (sb.cleaned_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
